[hdl/swl_pkg.sv]
// ----------------------------------------------------------------------------
// swl_pkg: shared constants of the single-wire LED frame sender
// Frame defaults, command codes, bit phase codes, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swl_pkg;

    // frame length default
    localparam int unsigned FRAME_BITS_DEF = 32;

    // write byte that opens every frame
    localparam logic [7:0] WRITE_BYTE = 8'h3A;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SEND   = 3'd1;
    localparam logic [2:0] CMD_ON     = 3'd2;
    localparam logic [2:0] CMD_OFF    = 3'd3;
    localparam logic [2:0] CMD_TOGGLE = 3'd4;
    localparam logic [2:0] CMD_STORE  = 3'd5;

    // bit phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PULSE1   = 3'd1;
    localparam logic [2:0] PH_LOW_FULL = 3'd2;
    localparam logic [2:0] PH_LOW_A    = 3'd3;
    localparam logic [2:0] PH_PULSE2   = 3'd4;
    localparam logic [2:0] PH_LOW_B    = 3'd5;

    // register map
    localparam int unsigned  ADDR_W    = 4;
    localparam logic [1:0]   REG_TICKS = 2'd0;
    localparam logic [1:0]   REG_PULSE = 2'd1;
    localparam logic [1:0]   REG_CYCLE = 2'd2;

    localparam logic [7:0] TICKS_RST = 8'd32;
    localparam logic [7:0] PULSE_RST = 8'd5;
    localparam logic [7:0] CYCLE_RST = 8'd25;

endpackage

`default_nettype wire

[hdl/swl_ifs.sv]
// ----------------------------------------------------------------------------
// swl_ifs: channel interfaces of the single-wire LED frame sender
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface swl_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, command, red, green, blue, input ready);
    modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface swl_res_if;
    logic valid;
    logic ready;
    logic data_line;
    logic select_line;
    logic busy_res;
    logic rejected;

    modport source (output valid, data_line, select_line, busy_res, rejected, input ready);
    modport sink   (input valid, data_line, select_line, busy_res, rejected, output ready);
endinterface

`default_nettype wire

[hdl/single_wire_led_frame_sender.sv]
// Path: an accepted command beat goes into the input register, and its result beat
//   comes from the state update and the result register once the result channel is free.
// Throughput: one command beat per cycle while results are taken; the frame
//   state updates once per beat, so each tick beat is one line tick.
// Reset: synchronous, active low; clears line state, colour, LED on/off flag
//   and restores register defaults (32 ticks/us, 5 us pulse, 25 us cycle).
// ----------------------------------------------------------------------------
// single_wire_led_frame_sender: single-wire RGB LED frame sender
// Runs pulse-coded frames (write byte, red, green, blue) on a data line,
// with select held high while a frame goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_led_frame_sender
    import swl_pkg::*;
#(
    parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    swl_cmd_if.sink                i_cmd,
    swl_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int unsigned BL_W   = $clog2(FRAME_BITS + 1);
    localparam int unsigned WIDE_W = (FRAME_BITS > 32) ? FRAME_BITS : 32;

    // configuration registers
    logic [7:0] r_ticks, r_pulse, r_cycle;

    // input register
    logic       r_in_vld;
    logic [2:0] r_cmd;
    logic [7:0] r_red, r_green, r_blue;

    // frame state
    logic [23:0]           r_colour, n_colour;
    logic                  r_led_on, n_led_on;
    logic [FRAME_BITS-1:0] r_shift,  n_shift;
    logic [BL_W-1:0]       r_bits,   n_bits;
    logic [2:0]            r_phase,  n_phase;
    logic [15:0]           r_wait,   n_wait;
    logic                  r_sending, n_sending;
    logic                  r_level,  n_level;
    logic                  n_rejected;

    // result register
    logic r_out_vld;
    logic r_out_data, r_out_sel, r_out_busy, r_out_rej;

    logic fire;
    logic cfg_wr;

    assign fire        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || fire;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_TICKS: prdata = {24'd0, r_ticks};
            REG_PULSE: prdata = {24'd0, r_pulse};
            REG_CYCLE: prdata = {24'd0, r_cycle};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RST;
            r_pulse <= PULSE_RST;
            r_cycle <= CYCLE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TICKS: r_ticks <= pwdata[7:0];
                REG_PULSE: r_pulse <= pwdata[7:0];
                REG_CYCLE: r_cycle <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // next frame state for the beat in the input register
    always_comb begin
        logic       start;
        logic [23:0] start_colour;
        logic       seg_load;
        logic [7:0] seg_us;
        logic [15:0] seg_prod;
        logic [WIDE_W-1:0] frame_wide;
        logic [BL_W-1:0]   bits_dec;

        n_colour   = r_colour;
        n_led_on   = r_led_on;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_sending  = r_sending;
        n_level    = r_level;
        n_rejected = 1'b0;

        start        = 1'b0;
        start_colour = r_colour;
        seg_load     = 1'b0;
        seg_us       = r_pulse;
        bits_dec     = (r_bits != '0) ? r_bits - BL_W'(1) : r_bits;

        case (r_cmd)
            CMD_TICK: begin
                if (r_sending) begin
                    if (r_wait > 16'd1) begin
                        n_wait = r_wait - 16'd1;
                    end else begin
                        case (r_phase)
                            PH_PULSE1: begin
                                n_level  = 1'b0;
                                seg_load = 1'b1;
                                if (r_shift[FRAME_BITS-1]) begin
                                    n_phase = PH_LOW_A;
                                    seg_us  = {1'b0, r_cycle[7:1]};
                                end else begin
                                    n_phase = PH_LOW_FULL;
                                    seg_us  = r_cycle;
                                end
                            end
                            PH_LOW_A: begin
                                n_phase  = PH_PULSE2;
                                n_level  = 1'b1;
                                seg_load = 1'b1;
                                seg_us   = r_pulse;
                            end
                            PH_PULSE2: begin
                                n_phase  = PH_LOW_B;
                                n_level  = 1'b0;
                                seg_load = 1'b1;
                                seg_us   = {1'b0, r_cycle[7:1]};
                            end
                            default: begin
                                // end of a bit: shift, then next bit or frame end
                                n_bits  = bits_dec;
                                n_shift = r_shift << 1;
                                if (bits_dec != '0) begin
                                    n_phase  = PH_PULSE1;
                                    n_level  = 1'b1;
                                    seg_load = 1'b1;
                                    seg_us   = r_pulse;
                                end else begin
                                    n_sending = 1'b0;
                                    n_level   = 1'b0;
                                    n_phase   = PH_IDLE;
                                    n_wait    = 16'd0;
                                end
                            end
                        endcase
                    end
                end
            end
            CMD_SEND, CMD_ON, CMD_OFF, CMD_TOGGLE, CMD_STORE: begin
                if (r_sending) begin
                    n_rejected = 1'b1;
                end else begin
                    case (r_cmd)
                        CMD_SEND: begin
                            n_colour     = {r_red, r_green, r_blue};
                            start_colour = {r_red, r_green, r_blue};
                            n_led_on     = 1'b1;
                            start        = 1'b1;
                        end
                        CMD_ON: begin
                            n_led_on = 1'b1;
                            start    = 1'b1;
                        end
                        CMD_OFF: begin
                            n_led_on     = 1'b0;
                            start_colour = 24'd0;
                            start        = 1'b1;
                        end
                        CMD_TOGGLE: begin
                            n_led_on     = !r_led_on;
                            start_colour = r_led_on ? 24'd0 : r_colour;
                            start        = 1'b1;
                        end
                        default: begin
                            n_colour = {r_red, r_green, r_blue};
                        end
                    endcase
                end
            end
            default: ;
        endcase

        frame_wide = WIDE_W'({WRITE_BYTE, start_colour});
        if (start) begin
            n_shift   = frame_wide[FRAME_BITS-1:0];
            n_bits    = BL_W'(FRAME_BITS);
            n_sending = 1'b1;
            n_phase   = PH_PULSE1;
            n_level   = 1'b1;
            seg_load  = 1'b1;
            seg_us    = r_pulse;
        end

        // segment length in ticks, at least one
        seg_prod = 16'(seg_us) * 16'(r_ticks);
        if (seg_load) begin
            n_wait = (seg_prod == 16'd0) ? 16'd1 : seg_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_colour  <= 24'd0;
            r_led_on  <= 1'b0;
            r_shift   <= '0;
            r_bits    <= '0;
            r_phase   <= PH_IDLE;
            r_wait    <= 16'd0;
            r_sending <= 1'b0;
            r_level   <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_vld <= i_cmd.valid;
            end
            if (fire) begin
                r_colour  <= n_colour;
                r_led_on  <= n_led_on;
                r_shift   <= n_shift;
                r_bits    <= n_bits;
                r_phase   <= n_phase;
                r_wait    <= n_wait;
                r_sending <= n_sending;
                r_level   <= n_level;
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd   <= i_cmd.command;
            r_red   <= i_cmd.red;
            r_green <= i_cmd.green;
            r_blue  <= i_cmd.blue;
        end
        if (fire) begin
            r_out_data <= n_level;
            r_out_sel  <= n_sending;
            r_out_busy <= n_sending;
            r_out_rej  <= n_rejected;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.data_line   = r_out_data;
    assign o_res.select_line = r_out_sel;
    assign o_res.busy_res    = r_out_busy;
    assign o_res.rejected    = r_out_rej;

endmodule

`default_nettype wire

[hdl/swl_chk.sv]
// ----------------------------------------------------------------------------
// swl_chk: port checker of the single-wire LED frame sender
// Watches the result channel and flags inconsistent line levels.
// ----------------------------------------------------------------------------
`default_nettype none

module swl_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire logic i_data_line,
    input wire logic i_select_line,
    input wire logic i_busy_res,
    input wire logic i_rejected
);

    // select and busy follow the same frame flag
    a_sel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_select_line == i_busy_res))
        else $error("select_line and busy_res differ");

    // data only goes high inside a frame
    a_data_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_data_line) |-> i_select_line)
        else $error("data_line high outside a frame");

    // a command is only dropped while a frame runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_rejected) |-> i_busy_res)
        else $error("rejected while idle");

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_data_line)
            && $stable(i_select_line) && $stable(i_rejected)))
        else $error("stalled result beat changed");

endmodule

bind single_wire_led_frame_sender swl_chk u_swl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_data_line   (o_res.data_line),
    .i_select_line (o_res.select_line),
    .i_busy_res    (o_res.busy_res),
    .i_rejected    (o_res.rejected)
);

`default_nettype wire
